// ===== rtl/smm_pkg.sv =====
package smm_pkg;

  localparam int unsigned IDX_W    = 6;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned INNER_W  = 7;
  localparam int unsigned COLS_W   = 7;
  localparam int unsigned ROWS_W   = 13;
  localparam int unsigned ROWCNT_W = 12;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REGIDX_W = 2;

  localparam logic OP_WRITE_B  = 1'b0;
  localparam logic OP_STREAM_A = 1'b1;

  localparam logic [REGIDX_W-1:0] REG_INNER_SIZE   = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_ROW_COUNT    = 2'd2;

  localparam logic [VAL_W-1:0]  SAT_LIMIT = 8'd255;
  localparam logic [ROWS_W-1:0] ROW_LIMIT = 13'd4096;
  localparam int unsigned       INDEX_LIMIT = 64;

  typedef struct packed {
    logic [INNER_W-1:0] inner_size;
    logic [COLS_W-1:0]  column_count;
    logic [ROWS_W-1:0]  row_count;
  } cfg_t;

endpackage

// ===== rtl/smm_in_if.sv =====
interface smm_in_if;
  import smm_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] inner_index;
  logic [IDX_W-1:0] column_index;
  logic [VAL_W-1:0] element_value;

  modport source (
    output valid, operation, inner_index, column_index, element_value,
    input  ready
  );

  modport sink (
    input  valid, operation, inner_index, column_index, element_value,
    output ready
  );
endinterface

// ===== rtl/smm_out_if.sv =====
interface smm_out_if;
  import smm_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] product_column;
  logic [VAL_W-1:0] product_value;
  logic             last_of_row;
  logic             last_of_matrix;

  modport source (
    output valid, product_column, product_value, last_of_row, last_of_matrix,
    input  ready
  );

  modport sink (
    input  valid, product_column, product_value, last_of_row, last_of_matrix,
    output ready
  );
endinterface

// ===== rtl/smm_apb_regs.sv =====
module smm_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smm_pkg::PADDR_W-1:0]   paddr,
  input  logic [smm_pkg::PDATA_W-1:0]   pwdata,
  output logic [smm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output smm_pkg::cfg_t                 cfg_o
);
  import smm_pkg::*;

  cfg_t                cfg_q;
  cfg_t                cfg_d;
  logic [REGIDX_W-1:0] reg_idx;
  logic                wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_INNER_SIZE:   cfg_d.inner_size   = pwdata[INNER_W-1:0];
        REG_COLUMN_COUNT: cfg_d.column_count = pwdata[COLS_W-1:0];
        REG_ROW_COUNT:    cfg_d.row_count    = pwdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INNER_SIZE:   prdata = PDATA_W'(cfg_q.inner_size);
      REG_COLUMN_COUNT: prdata = PDATA_W'(cfg_q.column_count);
      REG_ROW_COUNT:    prdata = PDATA_W'(cfg_q.row_count);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner_size   <= INNER_W'(1);
      cfg_q.column_count <= COLS_W'(1);
      cfg_q.row_count    <= ROWS_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

// ===== rtl/saturating_u8_matrix_multiply.sv =====
// Saturating unsigned 8-bit matrix multiply. Load B with operation-0 words, one element per
// word; B is held in a synchronous memory that is never cleared, so every element that a
// product uses must be written first. Then stream A row by row with operation-1 words. For each
// A word, one multiply-accumulate per cycle walks the column accumulator memory with a single
// read and a single write port. After the word with the last inner index, the row is emitted
// as column_count result words, each passing S_EMIT_RD and then S_EMIT_WR and held back while
// the output is not taken, and the accumulators are cleared at once. A words with an inner
// index at or above inner_size (read as 1 when zero) are accepted and dropped.
module saturating_u8_matrix_multiply #(
  parameter int unsigned MAX_INNER   = 64,
  parameter int unsigned MAX_COLUMNS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  smm_in_if.sink                        in_chan_i,
  smm_out_if.source                     out_chan_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smm_pkg::PADDR_W-1:0]   paddr,
  input  logic [smm_pkg::PDATA_W-1:0]   pwdata,
  output logic [smm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import smm_pkg::*;

  localparam int unsigned ROWS_B  = (MAX_INNER < INDEX_LIMIT) ? MAX_INNER : INDEX_LIMIT;
  localparam int unsigned RBW     = (ROWS_B > 1) ? $clog2(ROWS_B) : 1;
  localparam int unsigned CW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned B_DEPTH = ROWS_B * (2 ** CW);
  localparam logic [INNER_W-1:0] INNER_HI = INNER_W'(ROWS_B);
  localparam logic [COLS_W-1:0]  COLS_HI  = COLS_W'(MAX_COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_MAC_END,
    S_EMIT_RD,
    S_EMIT_WR
  } state_e;

  cfg_t cfg;

  smm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [INNER_W-1:0] inner_eff;
  logic [COLS_W-1:0]  cols_eff;
  logic [ROWS_W-1:0]  rows_eff;

  always_comb begin
    if (cfg.inner_size == '0) begin
      inner_eff = INNER_W'(1);
    end else if (cfg.inner_size > INNER_HI) begin
      inner_eff = INNER_HI;
    end else begin
      inner_eff = cfg.inner_size;
    end
    if (cfg.column_count == '0) begin
      cols_eff = COLS_W'(1);
    end else if (cfg.column_count > COLS_HI) begin
      cols_eff = COLS_HI;
    end else begin
      cols_eff = cfg.column_count;
    end
    if (cfg.row_count == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (cfg.row_count > ROW_LIMIT) begin
      rows_eff = ROW_LIMIT;
    end else begin
      rows_eff = cfg.row_count;
    end
  end

  state_e                 state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [IDX_W-1:0]       a_k_q, a_k_d;
  logic [VAL_W-1:0]       a_val_q, a_val_d;
  logic                   last_k_q, last_k_d;
  logic                   last_mat_q, last_mat_d;
  logic [ROWCNT_W-1:0]    row_cnt_q, row_cnt_d;
  logic                   p_vld_q, p_vld_d;
  logic [CW-1:0]          p_col_q, p_col_d;
  logic [MAX_COLUMNS-1:0] acc_vld_q, acc_vld_d;
  logic                   acc_rv_q;
  logic                   out_vld_q, out_vld_d;
  logic [IDX_W-1:0]       out_col_q, out_col_d;
  logic [VAL_W-1:0]       out_val_q, out_val_d;
  logic                   out_lrow_q, out_lrow_d;
  logic                   out_lmat_q, out_lmat_d;

  logic [VAL_W-1:0]       b_mem [B_DEPTH];
  logic [VAL_W-1:0]       b_rdata_q;
  logic [RBW+CW-1:0]      b_waddr;
  logic [RBW+CW-1:0]      b_raddr;
  logic                   b_we;

  logic [VAL_W-1:0]       acc_mem [MAX_COLUMNS];
  logic [VAL_W-1:0]       acc_rdata_q;
  logic [VAL_W-1:0]       acc_cur;
  logic [2*VAL_W-1:0]     prod;
  logic [2*VAL_W:0]       sum;
  logic [VAL_W-1:0]       acc_wdata;
  logic                   acc_we;

  logic                   in_take;
  logic                   out_take;
  logic                   last_col;

  assign in_chan_i.ready = (state_q == S_IDLE);
  assign in_take         = in_chan_i.valid && in_chan_i.ready;
  assign out_take        = out_vld_q && out_chan_o.ready;
  assign last_col        = (COLS_W'(cnt_q) == (cols_eff - COLS_W'(1)));

  assign out_chan_o.valid          = out_vld_q;
  assign out_chan_o.product_column = out_col_q;
  assign out_chan_o.product_value  = out_val_q;
  assign out_chan_o.last_of_row    = out_lrow_q;
  assign out_chan_o.last_of_matrix = out_lmat_q;

  assign b_we    = in_take && (in_chan_i.operation == OP_WRITE_B)
                && (32'(in_chan_i.inner_index) < MAX_INNER)
                && (32'(in_chan_i.column_index) < MAX_COLUMNS);
  assign b_waddr = {in_chan_i.inner_index[RBW-1:0], in_chan_i.column_index[CW-1:0]};
  assign b_raddr = {a_k_q[RBW-1:0], cnt_q};

  assign acc_cur   = acc_rv_q ? acc_rdata_q : '0;
  assign prod      = a_val_q * b_rdata_q;
  assign sum       = {{(VAL_W+1){1'b0}}, acc_cur} + {1'b0, prod};
  assign acc_wdata = (sum > (2*VAL_W+1)'(SAT_LIMIT)) ? SAT_LIMIT : sum[VAL_W-1:0];
  assign acc_we    = p_vld_q;

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= in_chan_i.element_value;
    end
    b_rdata_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[p_col_q] <= acc_wdata;
    end
    acc_rdata_q <= acc_mem[cnt_q];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    a_k_d      = a_k_q;
    a_val_d    = a_val_q;
    last_k_d   = last_k_q;
    last_mat_d = last_mat_q;
    row_cnt_d  = row_cnt_q;
    p_vld_d    = 1'b0;
    p_col_d    = p_col_q;
    acc_vld_d  = acc_vld_q;
    out_vld_d  = out_take ? 1'b0 : out_vld_q;
    out_col_d  = out_col_q;
    out_val_d  = out_val_q;
    out_lrow_d = out_lrow_q;
    out_lmat_d = out_lmat_q;

    if (acc_we) begin
      acc_vld_d[p_col_q] = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_take && (in_chan_i.operation == OP_STREAM_A)
            && ({1'b0, in_chan_i.inner_index} < inner_eff)) begin
          a_k_d    = in_chan_i.inner_index;
          a_val_d  = in_chan_i.element_value;
          last_k_d = ({1'b0, in_chan_i.inner_index} == (inner_eff - INNER_W'(1)));
          cnt_d    = '0;
          state_d  = S_MAC;
        end
      end
      S_MAC: begin
        p_vld_d = 1'b1;
        p_col_d = cnt_q;
        if (last_col) begin
          state_d = S_MAC_END;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_MAC_END: begin
        cnt_d = '0;
        if (last_k_q) begin
          last_mat_d = ({1'b0, row_cnt_q} >= (rows_eff - ROWS_W'(1)));
          row_cnt_d  = last_mat_d ? '0 : (row_cnt_q + ROWCNT_W'(1));
          state_d    = S_EMIT_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        if (!out_vld_q || out_chan_o.ready) begin
          state_d = S_EMIT_WR;
        end
      end
      S_EMIT_WR: begin
        out_vld_d  = 1'b1;
        out_col_d  = IDX_W'(cnt_q);
        out_val_d  = acc_cur;
        out_lrow_d = last_col;
        out_lmat_d = last_col && last_mat_q;
        if (last_col) begin
          acc_vld_d = '0;
          cnt_d     = '0;
          state_d   = S_IDLE;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      a_k_q      <= '0;
      a_val_q    <= '0;
      last_k_q   <= 1'b0;
      last_mat_q <= 1'b0;
      row_cnt_q  <= '0;
      p_vld_q    <= 1'b0;
      p_col_q    <= '0;
      acc_vld_q  <= '0;
      acc_rv_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      out_col_q  <= '0;
      out_val_q  <= '0;
      out_lrow_q <= 1'b0;
      out_lmat_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      a_k_q      <= a_k_d;
      a_val_q    <= a_val_d;
      last_k_q   <= last_k_d;
      last_mat_q <= last_mat_d;
      row_cnt_q  <= row_cnt_d;
      p_vld_q    <= p_vld_d;
      p_col_q    <= p_col_d;
      acc_vld_q  <= acc_vld_d;
      acc_rv_q   <= acc_vld_q[cnt_q];
      out_vld_q  <= out_vld_d;
      out_col_q  <= out_col_d;
      out_val_q  <= out_val_d;
      out_lrow_q <= out_lrow_d;
      out_lmat_q <= out_lmat_d;
    end
  end

  a_mac_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC && p_vld_q) |-> (p_col_q != cnt_q))
    else $error("accumulator write hits the entry being read");

  a_out_loaded_by_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_EMIT_WR))
    else $error("output word loaded outside emission");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_WR) |-> !out_vld_q)
    else $error("emission would overwrite a pending output word");

  a_matrix_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_lmat_q) |-> out_lrow_q)
    else $error("matrix end flagged away from a row end");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q == S_EMIT_WR)) |-> (acc_vld_q == '0))
    else $error("accumulators not cleared after a row");
endmodule
